FILE: hdl/sbpws_pkg.sv
// Shared types, constants and codes for the status blink WS2812 encoder.
package sbpws_pkg;

  localparam int FRAME_BITS      = 24;
  localparam int RESET_WORDS_DEF = 40;
  localparam int DUTY_W          = 6;
  localparam int STATUS_W        = 4;
  localparam int CODE_W          = 8;
  localparam int TICK_W          = 32;
  localparam int EVAL_GAP        = 5;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 6'd42;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 6'd18;

  typedef enum logic [0:0] {
    REG_DUTY_ONE  = 1'b0,
    REG_DUTY_ZERO = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_INIT       = 4'd0;
  localparam logic [STATUS_W-1:0] ST_READY      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_SET_ADDR   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_CURRENT    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_OFFLINE    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_START_FAIL = 4'd5;
  localparam logic [STATUS_W-1:0] ST_VOLTAGE    = 4'd6;
  localparam logic [STATUS_W-1:0] ST_ALARM      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_MOS        = 4'd8;
  localparam logic [STATUS_W-1:0] ST_ADDR_DONE  = 4'd9;

  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } grb_t;

  localparam grb_t C_YELLOW = '{g: 8'd150, r: 8'd255, b: 8'd0};
  localparam grb_t C_GREEN  = '{g: 8'd255, r: 8'd0,   b: 8'd0};
  localparam grb_t C_PURPLE = '{g: 8'd0,   r: 8'd160, b: 8'd255};
  localparam grb_t C_ORANGE = '{g: 8'd60,  r: 8'd255, b: 8'd0};
  localparam grb_t C_BLUE   = '{g: 8'd0,   r: 8'd0,   b: 8'd255};
  localparam grb_t C_WHITE  = '{g: 8'd255, r: 8'd255, b: 8'd255};
  localparam grb_t C_CYAN   = '{g: 8'd180, r: 8'd0,   b: 8'd255};
  localparam grb_t C_RED    = '{g: 8'd0,   r: 8'd255, b: 8'd0};
  localparam grb_t C_OFF    = '{g: 8'd0,   r: 8'd0,   b: 8'd0};

endpackage

FILE: hdl/sbpws_front.sv
// Front end: takes ticks and status requests, keeps timing state, picks the colour.
module sbpws_front
  import sbpws_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [STATUS_W-1:0] in_status,
  input  logic [CODE_W-1:0]   in_code,
  output logic                push,
  output grb_t                push_colour,
  input  logic                full
);

  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [TICK_W-1:0]   last_eval, last_eval_next;
  logic [STATUS_W-1:0] cur_status, cur_status_next;
  logic [CODE_W-1:0]   blink_code, blink_code_next;

  // phase counters: c200/f give (t mod 2500)/200, c250/g give (t mod 3000)/250
  logic [7:0] c200, c200_next;
  logic [3:0] f200, f200_next;
  logic [7:0] c250, c250_next;
  logic [3:0] g250, g250_next;
  logic [8:0] c300, c300_next;
  logic       p300, p300_next;
  logic [8:0] c400, c400_next;
  logic       p400, p400_next;

  logic              accept;
  logic              eval;
  logic              zero_phase;
  logic              mos_wrap;
  logic [TICK_W-1:0] gap;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign mos_wrap = (f200 == 4'd12) && (c200 == 8'd99);
  assign gap      = tick_count_next - last_eval;

  always_comb begin
    tick_count_next = tick_count;
    last_eval_next  = last_eval;
    cur_status_next = cur_status;
    blink_code_next = blink_code;
    c200_next = c200;
    f200_next = f200;
    c250_next = c250;
    g250_next = g250;
    c300_next = c300;
    p300_next = p300;
    c400_next = c400;
    p400_next = p400;
    eval       = 1'b0;
    zero_phase = 1'b0;
    if (accept) begin
      if (in_cmd == CMD_TICK) begin
        tick_count_next = tick_count + 1'b1;
        zero_phase = (tick_count == '1);
        c200_next = (c200 == 8'd199 || mos_wrap) ? 8'd0 : c200 + 8'd1;
        f200_next = mos_wrap ? 4'd0 : ((c200 == 8'd199) ? f200 + 4'd1 : f200);
        c250_next = (c250 == 8'd249) ? 8'd0 : c250 + 8'd1;
        g250_next = (c250 == 8'd249) ? ((g250 == 4'd11) ? 4'd0 : g250 + 4'd1) : g250;
        c300_next = (c300 == 9'd299) ? 9'd0 : c300 + 9'd1;
        p300_next = (c300 == 9'd299) ? !p300 : p300;
        c400_next = (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
        p400_next = (c400 == 9'd399) ? !p400 : p400;
        if (gap >= TICK_W'(EVAL_GAP)) begin
          eval           = 1'b1;
          last_eval_next = tick_count_next;
        end
      end else if (in_status != cur_status || in_code != blink_code) begin
        cur_status_next = in_status;
        blink_code_next = in_code;
        tick_count_next = '0;
        last_eval_next  = '0;
        zero_phase      = 1'b1;
        eval            = 1'b1;
      end
      if (zero_phase) begin
        c200_next = '0;
        f200_next = '0;
        c250_next = '0;
        g250_next = '0;
        c300_next = '0;
        p300_next = 1'b0;
        c400_next = '0;
        p400_next = 1'b0;
      end
    end
  end

  always_comb begin
    case (cur_status_next)
      ST_INIT:       push_colour = C_YELLOW;
      ST_READY:      push_colour = C_GREEN;
      ST_SET_ADDR:   push_colour = C_PURPLE;
      ST_CURRENT:    push_colour = p300_next ? C_OFF : C_ORANGE;
      ST_OFFLINE:    push_colour = p300_next ? C_OFF : C_BLUE;
      ST_START_FAIL: push_colour = g250_next[0] ? C_OFF : C_WHITE;
      ST_VOLTAGE:    push_colour = p300_next ? C_OFF : C_CYAN;
      ST_ALARM:      push_colour = p400_next ? C_BLUE : C_GREEN;
      ST_MOS:
        push_colour = ({5'd0, f200_next} < {blink_code_next, 1'b0} && !f200_next[0])
                      ? C_RED : C_OFF;
      ST_ADDR_DONE:
        push_colour = ({5'd0, g250_next} < {blink_code_next, 1'b0} && !g250_next[0])
                      ? C_PURPLE : C_OFF;
      default:       push_colour = C_OFF;
    endcase
  end

  assign push = eval;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      last_eval  <= '0;
      cur_status <= ST_INIT;
      blink_code <= '0;
      c200 <= '0;
      f200 <= '0;
      c250 <= '0;
      g250 <= '0;
      c300 <= '0;
      p300 <= 1'b0;
      c400 <= '0;
      p400 <= 1'b0;
    end else begin
      tick_count <= tick_count_next;
      last_eval  <= last_eval_next;
      cur_status <= cur_status_next;
      blink_code <= blink_code_next;
      c200 <= c200_next;
      f200 <= f200_next;
      c250 <= c250_next;
      g250 <= g250_next;
      c300 <= c300_next;
      p300 <= p300_next;
      c400 <= c400_next;
      p400 <= p400_next;
    end
  end

endmodule

FILE: hdl/sbpws_queue.sv
// Two-entry colour queue between front end and frame serialiser.
module sbpws_queue
  import sbpws_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grb_t push_colour,
  output logic full,
  input  logic pop,
  output grb_t pop_colour,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  grb_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full       = (fill == (PW+1)'(QUEUE_DEPTH));
  assign empty      = (fill == '0);
  assign pop_colour = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/sbpws_back.sv
// Back end: duty registers and serialiser of 24 bit colour frames plus reset slots.
module sbpws_back
  import sbpws_pkg::*;
#(
  parameter int RESET_WORDS = RESET_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [DUTY_W-1:0] cfg_data,
  input  logic              empty,
  input  grb_t              pop_colour,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] out_duty,
  output logic              out_last
);

  localparam int TOTAL = FRAME_BITS + RESET_WORDS;
  localparam int CW    = $clog2(TOTAL);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t                   state;
  logic [DUTY_W-1:0]        duty_one;
  logic [DUTY_W-1:0]        duty_zero;
  logic [FRAME_BITS-1:0]    shreg;
  logic [CW-1:0]            cnt;
  logic                     advance;
  logic                     final_word;

  assign cfg_ready  = 1'b1;
  assign pop        = (state == S_IDLE) && !empty;
  assign advance    = (state == S_SEND) && (!out_valid || out_ready);
  assign final_word = (cnt == CW'(TOTAL - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_one  <= DUTY_ONE_RST;
      duty_zero <= DUTY_ZERO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DUTY_ONE:  duty_one  <= cfg_data;
        REG_DUTY_ZERO: duty_zero <= cfg_data;
        default:       duty_one  <= duty_one;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !advance) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_SEND;
            cnt   <= '0;
          end
        end
        S_SEND: begin
          if (advance) begin
            out_valid <= 1'b1;
            cnt       <= cnt + 1'b1;
            if (final_word) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= pop_colour;
    end else if (advance) begin
      shreg <= {shreg[FRAME_BITS-2:0], 1'b0};
    end
    if (advance) begin
      if (cnt < CW'(FRAME_BITS)) begin
        out_duty <= shreg[FRAME_BITS-1] ? duty_one : duty_zero;
      end else begin
        out_duty <= '0;
      end
      out_last <= final_word;
    end
  end

endmodule

FILE: hdl/status_blink_pattern_ws2812_encoder.sv
// Top level of the status blink WS2812 PWM encoder.
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   s_tuser: cmd; s_tdata: status, code
//  m_       out  m_tvalid / m_tready   m_tdata: duty; m_tlast: last
//  cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle is taken while the colour queue (two frames) has room.
// Each frame is 24 + RESET_WORDS words, one word per cycle unless the output
// stalls, set by the serialiser counter; the idle state lies between frames.
// Reset is synchronous; the duty registers return to 42 and 18.
// Output stalls hold the word; the front end stalls only when the queue fills.
module status_blink_pattern_ws2812_encoder
  import sbpws_pkg::*;
#(
  parameter int RESET_WORDS = RESET_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [3:0] status, [11:4] code, zero fill
  input  logic              s_tuser,   // [0] cmd
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [5:0] duty, zero fill
  output logic              m_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [DUTY_W-1:0] cfg_data
);

  logic              push;
  grb_t              push_colour;
  logic              full;
  logic              pop;
  grb_t              pop_colour;
  logic              empty;
  logic [DUTY_W-1:0] duty;

  sbpws_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_status   (s_tdata[3:0]),
    .in_code     (s_tdata[11:4]),
    .push        (push),
    .push_colour (push_colour),
    .full        (full)
  );

  sbpws_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_colour (push_colour),
    .full        (full),
    .pop         (pop),
    .pop_colour  (pop_colour),
    .empty       (empty)
  );

  sbpws_back #(
    .RESET_WORDS (RESET_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop_colour (pop_colour),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_duty   (duty),
    .out_last   (m_tlast)
  );

  assign m_tdata = {2'b00, duty};

endmodule

FILE: hdl/sbpws_checker.sv
// Port-level checks on the encoder, bound to the top level.
module sbpws_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:6] == 2'b00)
    else $error("padding bits of duty word set");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'd0)
    else $error("final word of frame is not a reset slot");

endmodule

bind status_blink_pattern_ws2812_encoder sbpws_checker u_sbpws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
